/* rtl/acss_pkg.sv */
// Shared types, codes and constants of the converter SPI command slave.
package acss_pkg;

    localparam int REG_COUNT_DEF   = 27;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int ADDR_SPAN       = 32;

    localparam logic [7:0] OPCODE_RESET  = 8'h12;
    localparam logic [2:0] RREG_PATTERN  = 3'b001;
    localparam logic [2:0] WREG_PATTERN  = 3'b010;
    localparam logic [7:0] STATUS_NEW    = 8'h40;
    localparam logic [7:0] CHECKSUM_SEED = 8'h9b;

    localparam logic [1:0] CMD_BYTE   = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;
    localparam logic [1:0] CMD_SAMPLE = 2'd2;

    localparam logic [2:0] POS_OPCODE   = 3'd0;
    localparam logic [2:0] POS_COUNT    = 3'd1;
    localparam logic [2:0] POS_STATUS   = 3'd1;
    localparam logic [2:0] POS_SAMPLE0  = 3'd2;
    localparam logic [2:0] POS_SAMPLE1  = 3'd3;
    localparam logic [2:0] POS_SAMPLE2  = 3'd4;
    localparam logic [2:0] POS_SAMPLE3  = 3'd5;
    localparam logic [2:0] POS_CHECKSUM = 3'd6;
    localparam logic [2:0] POS_LAST     = 3'd7;

    typedef enum logic [1:0] {
        OP_BYTE,
        OP_START,
        OP_SAMPLE
    } t_op_kind;

    typedef enum logic [1:0] {
        FRAME_IDLE,
        FRAME_RREG,
        FRAME_WREG,
        FRAME_DATA
    } t_frame_kind;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [7:0]         mosi_byte;
        logic signed [31:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [7:0] miso_byte;
        logic       reg_written;
        logic [4:0] write_address;
    } t_out_item;

    typedef struct packed {
        t_op_kind    kind;
        logic [7:0]  mosi;
        logic [31:0] sample;
    } t_op;

endpackage

/* rtl/adc_spi_command_slave.sv */
// Top level of the converter SPI command slave: front end, queue and back end.
//
// One host request per clock while not held off: every SPI byte, frame start or new sample
// is queued. A byte's reply is loaded into the output register at the edge where the back end
// takes it from the queue, which it does when the output register is empty or not stalled.
// The front end is held off in reset and until r_seen is set, otherwise only when the queue
// is full, which happens only while the result side stalls. Frame starts, samples and unused
// command codes give no result. The read-data opcode register may be written only while idle.
module adc_spi_command_slave #(
    parameter int REG_COUNT   = acss_pkg::REG_COUNT_DEF,
    parameter int QUEUE_DEPTH = acss_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  acss_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output acss_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_data
);
    import acss_pkg::*;

    logic q_push, q_full, q_pop, q_valid;
    t_op  q_in_op, q_out_op;

    assign o_cfg_ready = 1'b1;

    acss_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_op     (q_in_op)
    );

    acss_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (q_in_op),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_op    (q_out_op)
    );

    acss_back #(
        .REG_COUNT (REG_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .i_q_op      (q_out_op),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

/* rtl/acss_front.sv */
// Front end: takes requests from the host side and classifies them into queue operations.
module acss_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  acss_pkg::t_in_item i_in_data,
    input  logic              i_q_full,
    output logic              o_q_push,
    output acss_pkg::t_op     o_q_op
);
    import acss_pkg::*;

    logic r_seen;   // marks that reset has been released at least once
    logic keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else begin
            r_seen <= 1'b1;
        end
    end

    always_comb begin
        keep          = 1'b1;
        o_q_op.kind   = OP_BYTE;
        o_q_op.mosi   = i_in_data.mosi_byte;
        o_q_op.sample = i_in_data.sample;
        unique case (i_in_data.cmd)
            CMD_BYTE:   o_q_op.kind = OP_BYTE;
            CMD_START:  o_q_op.kind = OP_START;
            CMD_SAMPLE: o_q_op.kind = OP_SAMPLE;
            default:    keep = 1'b0;   // drop unused code
        endcase
    end

    // hold off the host until r_seen is set after reset, or while the queue is full
    assign o_in_stall = i_q_full || !r_seen;
    assign o_q_push   = i_in_valid && !o_in_stall && keep;

endmodule

/* rtl/acss_queue.sv */
// Short queue of classified operations between the front and back ends.
module acss_queue #(
    parameter int QUEUE_DEPTH = acss_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  acss_pkg::t_op i_op,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output acss_pkg::t_op o_op
);
    import acss_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_op           r_slot [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= bump(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= bump(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_op;
        end
    end

endmodule

/* rtl/acss_back.sv */
// Back end: frame decoding, register file, sample readout and the output register.
module acss_back #(
    parameter int REG_COUNT = acss_pkg::REG_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_q_valid,
    input  acss_pkg::t_op      i_q_op,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output acss_pkg::t_out_item o_out_data
);
    import acss_pkg::*;

    localparam int RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    logic [7:0]  r_opcode;
    logic [7:0]  r_regs [REG_COUNT];
    logic [2:0]  r_pos, n_pos;
    t_frame_kind r_kind, n_kind;
    logic [4:0]  r_addr, n_addr;
    logic [5:0]  r_left, n_left;
    logic [31:0] r_latched, n_latched;
    logic [31:0] r_pending, n_pending;
    logic        r_flag, n_flag;
    logic        r_out_valid;
    t_out_item   r_out;
    t_out_item   res;

    logic        take;
    logic        is_byte;
    logic        addr_ok;
    logic        reg_slot;
    logic [8:0]  count;
    logic [5:0]  room;
    logic [7:0]  checksum;

    assign take     = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_q_pop  = take;
    assign is_byte  = take && (i_q_op.kind == OP_BYTE);
    assign addr_ok  = ({1'b0, r_addr} < 6'(REG_COUNT));
    assign reg_slot = (r_kind == FRAME_RREG || r_kind == FRAME_WREG)
                      && r_pos != POS_OPCODE && r_pos != POS_COUNT && r_left != '0;
    assign count    = {1'b0, i_q_op.mosi} + 9'd1;
    assign room     = 6'(ADDR_SPAN) - {1'b0, r_addr};
    assign checksum = r_latched[31:24] + r_latched[23:16] + r_latched[15:8]
                      + r_latched[7:0] + CHECKSUM_SEED;

    // next state
    always_comb begin
        n_pos     = r_pos;
        n_kind    = r_kind;
        n_addr    = r_addr;
        n_left    = r_left;
        n_latched = r_latched;
        n_pending = r_pending;
        n_flag    = r_flag;
        if (take) begin
            unique case (i_q_op.kind)
                OP_START: begin
                    n_pos  = POS_OPCODE;
                    n_kind = FRAME_IDLE;
                    n_left = '0;
                end
                OP_SAMPLE: begin
                    n_pending = i_q_op.sample;
                    n_flag    = 1'b1;
                end
                OP_BYTE: begin
                    if (r_pos == POS_OPCODE) begin
                        n_left = '0;
                        if (i_q_op.mosi == r_opcode) begin
                            n_kind    = FRAME_DATA;
                            n_latched = r_pending;
                        end else if (i_q_op.mosi[7:5] == RREG_PATTERN) begin
                            n_kind = FRAME_RREG;
                            n_addr = i_q_op.mosi[4:0];
                        end else if (i_q_op.mosi[7:5] == WREG_PATTERN) begin
                            n_kind = FRAME_WREG;
                            n_addr = i_q_op.mosi[4:0];
                        end else begin
                            n_kind = FRAME_IDLE;
                        end
                    end else if (r_kind == FRAME_RREG || r_kind == FRAME_WREG) begin
                        if (r_pos == POS_COUNT) begin
                            n_left = (count < {3'b000, room}) ? count[5:0] : room;
                        end else if (r_left != '0) begin
                            n_left = r_left - 6'd1;
                            n_addr = r_addr + 5'd1;
                        end
                    end else if (r_kind == FRAME_DATA && r_pos == POS_STATUS) begin
                        n_flag = 1'b0;   // status read clears new-sample flag
                    end
                    if (r_pos != POS_LAST) begin
                        n_pos = r_pos + 3'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // result of a byte slot
    always_comb begin
        res = '0;
        if (r_pos != POS_OPCODE) begin
            if (reg_slot && addr_ok) begin
                if (r_kind == FRAME_RREG) begin
                    res.miso_byte = r_regs[r_addr[RW-1:0]];
                end else begin
                    res.reg_written   = 1'b1;
                    res.write_address = r_addr;
                end
            end else if (r_kind == FRAME_DATA) begin
                case (r_pos)
                    POS_STATUS:   res.miso_byte = r_flag ? STATUS_NEW : 8'h00;
                    POS_SAMPLE0:  res.miso_byte = r_latched[31:24];
                    POS_SAMPLE1:  res.miso_byte = r_latched[23:16];
                    POS_SAMPLE2:  res.miso_byte = r_latched[15:8];
                    POS_SAMPLE3:  res.miso_byte = r_latched[7:0];
                    POS_CHECKSUM: res.miso_byte = checksum;
                    default:      res.miso_byte = 8'h00;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opcode    <= OPCODE_RESET;
            r_pos       <= POS_OPCODE;
            r_kind      <= FRAME_IDLE;
            r_addr      <= '0;
            r_left      <= '0;
            r_latched   <= '0;
            r_pending   <= '0;
            r_flag      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < REG_COUNT; i++) begin
                r_regs[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_opcode <= i_cfg_data;
            end
            r_pos     <= n_pos;
            r_kind    <= n_kind;
            r_addr    <= n_addr;
            r_left    <= n_left;
            r_latched <= n_latched;
            r_pending <= n_pending;
            r_flag    <= n_flag;
            if (is_byte) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            for (int i = 0; i < REG_COUNT; i++) begin
                if (is_byte && res.reg_written && r_addr == 5'(i)) begin
                    r_regs[i] <= i_q_op.mosi;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_byte) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_byte && res.reg_written |-> {1'b0, res.write_address} < 6'(REG_COUNT))
        else $error("register write outside the file");

    a_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({2'b00, r_addr} + {1'b0, r_left}) <= 7'(ADDR_SPAN))
        else $error("register burst runs past the address space");

    a_status_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_byte && r_kind == FRAME_DATA && r_pos == POS_STATUS |=> !r_flag)
        else $error("new-sample flag not cleared after status");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid && $stable(r_out))
        else $error("stalled result lost or changed");

endmodule
